### rtl/core/pbb_pkg.sv
// shared types and constants of the primitive bounding box
`default_nettype none
package pbb_pkg;
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_POINT   = 2'd1,
    CMD_LINE    = 2'd2,
    CMD_ELLIPSE = 2'd3
  } cmd_e;

  localparam int unsigned ROT_BITS = 16;
  localparam int unsigned ANG_BITS = 40;   // cordic angle, 2^-22 degree units
  localparam int unsigned TRIG_BITS = 34;  // q2.30 with headroom for cordic growth
  localparam int unsigned UNITS_PER_DEG = 64;
  localparam int unsigned HALF_TURN = 180 * UNITS_PER_DEG;
  localparam int unsigned FULL_TURN = 2 * HALF_TURN;
  localparam int unsigned QUARTER_TURN = HALF_TURN / 2;
  localparam logic signed [TRIG_BITS-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [TRIG_BITS-1:0] Q30One = 34'sd1073741824;

  function automatic logic signed [ANG_BITS-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ANG_BITS-1:0] v;
    case (idx)
      5'd0: v = 40'sd188743680;
      5'd1: v = 40'sd111421900;
      5'd2: v = 40'sd58872272;
      5'd3: v = 40'sd29884485;
      5'd4: v = 40'sd15000234;
      5'd5: v = 40'sd7507429;
      5'd6: v = 40'sd3754631;
      5'd7: v = 40'sd1877430;
      5'd8: v = 40'sd938729;
      5'd9: v = 40'sd469366;
      5'd10: v = 40'sd234683;
      5'd11: v = 40'sd117342;
      5'd12: v = 40'sd58671;
      5'd13: v = 40'sd29335;
      5'd14: v = 40'sd14668;
      5'd15: v = 40'sd7334;
      5'd16: v = 40'sd3667;
      5'd17: v = 40'sd1833;
      5'd18: v = 40'sd917;
      5'd19: v = 40'sd458;
      5'd20: v = 40'sd229;
      5'd21: v = 40'sd115;
      5'd22: v = 40'sd57;
      5'd23: v = 40'sd29;
      5'd24: v = 40'sd14;
      5'd25: v = 40'sd7;
      5'd26: v = 40'sd4;
      5'd27: v = 40'sd2;
      5'd28: v = 40'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

### rtl/core/pbb_front.sv
// front end: classifies primitives, reduces the angle, checks semi-axes
`default_nettype none
module pbb_front #(
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic signed [COORD_BITS-1:0] fx_i,
  input  wire logic signed [COORD_BITS-1:0] fy_i,
  input  wire logic signed [COORD_BITS-1:0] sx_i,
  input  wire logic signed [COORD_BITS-1:0] sy_i,
  input  wire logic signed [15:0]           rot_i,
  output logic                              q_valid_o,
  input  wire logic                         q_ready_i,
  output logic [1:0]                        q_cmd_o,
  output logic                              q_rej_o,
  output logic                              q_flip_o,
  output logic signed [pbb_pkg::ROT_BITS:0] q_ang_o,
  output logic signed [COORD_BITS-1:0]      q_fx_o,
  output logic signed [COORD_BITS-1:0]      q_fy_o,
  output logic signed [COORD_BITS-1:0]      q_sx_o,
  output logic signed [COORD_BITS-1:0]      q_sy_o
);
  import pbb_pkg::*;

  // two-entry queue toward the back end
  localparam int unsigned Depth = 2;
  localparam int unsigned PW = 2 + 1 + 1 + (ROT_BITS + 1) + 4 * COORD_BITS;

  logic [PW-1:0] mem_q [Depth];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  // angle reduction: fold rotation into (-90, 90] degrees
  logic signed [ROT_BITS:0] a0, a1, ared;
  logic                     flip;
  logic                     rej;

  always_comb begin
    a0 = {rot_i[15], rot_i};
    // negative rotations may need two turns added to reach [0, 360)
    a1 = a0;
    if (a1 < 0) a1 = a1 + (ROT_BITS+1)'(FULL_TURN);
    if (a1 < 0) a1 = a1 + (ROT_BITS+1)'(FULL_TURN);
    if (a1 >= (ROT_BITS+1)'(FULL_TURN)) a1 = a1 - (ROT_BITS+1)'(FULL_TURN);
    flip = 1'b0;
    if (a1 > (ROT_BITS+1)'(QUARTER_TURN) && a1 <= (ROT_BITS+1)'(3 * QUARTER_TURN)) begin
      ared = a1 - (ROT_BITS+1)'(HALF_TURN);
      flip = 1'b1;
    end else if (a1 > (ROT_BITS+1)'(3 * QUARTER_TURN)) begin
      ared = a1 - (ROT_BITS+1)'(FULL_TURN);
    end else begin
      ared = a1;
    end
    rej = (cmd_i == CMD_ELLIPSE) && (sx_i <= 0 || sy_i <= 0);
  end

  assign in_ready_o = (cnt_q != 2'(Depth));
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {cmd_i, rej, flip, ared, fx_i, fy_i, sx_i, sy_i};
  end

  assign {q_cmd_o, q_rej_o, q_flip_o, q_ang_o, q_fx_o, q_fy_o, q_sx_o, q_sy_o} = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

### rtl/core/pbb_back.sv
// back end: cordic, corner products and the running box
`default_nettype none
module pbb_back #(
  parameter int unsigned COORD_BITS   = 32,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  output logic                              q_ready_o,
  input  wire logic [1:0]                   q_cmd_i,
  input  wire logic                         q_rej_i,
  input  wire logic                         q_flip_i,
  input  wire logic signed [pbb_pkg::ROT_BITS:0] q_ang_i,
  input  wire logic signed [COORD_BITS-1:0] q_fx_i,
  input  wire logic signed [COORD_BITS-1:0] q_fy_i,
  input  wire logic signed [COORD_BITS-1:0] q_sx_i,
  input  wire logic signed [COORD_BITS-1:0] q_sy_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0]      min_x_o,
  output logic signed [COORD_BITS-1:0]      max_x_o,
  output logic signed [COORD_BITS-1:0]      min_y_o,
  output logic signed [COORD_BITS-1:0]      max_y_o,
  output logic                              empty_o,
  output logic                              rej_o
);
  import pbb_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned WB = CB + 2;     // corner sums with headroom
  localparam int unsigned PB = CB + TRIG_BITS; // product width
  localparam int unsigned StepBits = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [CB-1:0] CMax = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMin = {1'b1, {(CB-1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROT   = 6'b000010,
    S_MUL   = 6'b000100,
    S_SUM   = 6'b001000,
    S_BOUND = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [StepBits-1:0] step_q;
  logic [1:0] mi_q;      // product index
  logic [1:0] bi_q;      // corner index
  logic signed [TRIG_BITS-1:0] x_q, y_q;
  logic signed [ANG_BITS-1:0]  z_q;
  logic flip_q, rej_q;
  logic signed [CB-1:0] fx_q, fy_q, sx_q, sy_q;
  logic signed [CB:0] prod_q [4];   // cax, say, sax, cay
  logic signed [WB-1:0] cx_q [4], cy_q [4];
  logic signed [CB-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic empty_q;

  // cordic step
  logic [4:0] sh;
  logic signed [TRIG_BITS-1:0] dx, dy;
  assign sh = 5'(step_q);
  assign dx = y_q >>> sh;
  assign dy = x_q >>> sh;

  function automatic logic signed [TRIG_BITS-1:0] clampq(input logic signed [TRIG_BITS-1:0] v);
    if (v > Q30One) return Q30One;
    if (v < -Q30One) return -Q30One;
    return v;
  endfunction

  function automatic logic signed [CB-1:0] sat(input logic signed [WB-1:0] v);
    if (v > WB'(CMax)) return CMax;
    if (v < WB'(CMin)) return CMin;
    return v[CB-1:0];
  endfunction

  // one rounded product per cycle
  logic signed [TRIG_BITS-1:0] s_t, c_t, tsel;
  logic signed [CB-1:0] asel;
  logic [CB-1:0] ua;
  logic [TRIG_BITS-1:0] ut;
  logic [PB-1:0] up;
  logic [CB:0] mag;
  logic neg;
  always_comb begin
    c_t = flip_q ? -clampq(x_q) : clampq(x_q);
    s_t = flip_q ? -clampq(y_q) : clampq(y_q);
    case (mi_q)
      2'd0: begin asel = sx_q; tsel = c_t; end
      2'd1: begin asel = sy_q; tsel = s_t; end
      2'd2: begin asel = sx_q; tsel = s_t; end
      default: begin asel = sy_q; tsel = c_t; end
    endcase
    neg = tsel[TRIG_BITS-1];   // axes are positive here
    ua = asel;
    ut = neg ? -tsel : tsel;
    up = PB'(ua) * PB'(ut) + (PB'(1) << 29);
    mag = (CB+1)'(up >> 30);
  end

  // corner under test
  logic signed [CB-1:0] bx, by;
  assign bx = sat(cx_q[bi_q]);
  assign by = sat(cy_q[bi_q]);

  assign q_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_valid_i) state_d = (q_cmd_i == CMD_ELLIPSE && !q_rej_i) ? S_ROT : S_OUT;
      S_ROT:   if (step_q == StepBits'(CORDIC_STEPS - 1)) state_d = S_MUL;
      S_MUL:   if (mi_q == 2'd3) state_d = S_SUM;
      S_SUM:   state_d = S_BOUND;
      S_BOUND: if (bi_q == 2'd3) state_d = S_OUT;
      S_OUT:   if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      mi_q    <= '0;
      bi_q    <= '0;
      min_x_q <= CMax;
      min_y_q <= CMax;
      max_x_q <= CMin;
      max_y_q <= CMin;
      empty_q <= 1'b1;
      rej_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (q_valid_i) begin
          rej_q  <= q_rej_i;
          step_q <= '0;
          mi_q   <= '0;
          bi_q   <= '0;
          case (q_cmd_i)
            CMD_CLEAR: begin
              min_x_q <= CMax; min_y_q <= CMax;
              max_x_q <= CMin; max_y_q <= CMin;
              empty_q <= 1'b1;
            end
            CMD_POINT: begin
              if (q_fx_i < min_x_q) min_x_q <= q_fx_i;
              if (q_fx_i > max_x_q) max_x_q <= q_fx_i;
              if (q_fy_i < min_y_q) min_y_q <= q_fy_i;
              if (q_fy_i > max_y_q) max_y_q <= q_fy_i;
              empty_q <= 1'b0;
            end
            CMD_LINE: begin
              min_x_q <= (q_sx_i < q_fx_i) ? ((q_sx_i < min_x_q) ? q_sx_i : min_x_q)
                                           : ((q_fx_i < min_x_q) ? q_fx_i : min_x_q);
              max_x_q <= (q_sx_i > q_fx_i) ? ((q_sx_i > max_x_q) ? q_sx_i : max_x_q)
                                           : ((q_fx_i > max_x_q) ? q_fx_i : max_x_q);
              min_y_q <= (q_sy_i < q_fy_i) ? ((q_sy_i < min_y_q) ? q_sy_i : min_y_q)
                                           : ((q_fy_i < min_y_q) ? q_fy_i : min_y_q);
              max_y_q <= (q_sy_i > q_fy_i) ? ((q_sy_i > max_y_q) ? q_sy_i : max_y_q)
                                           : ((q_fy_i > max_y_q) ? q_fy_i : max_y_q);
              empty_q <= 1'b0;
            end
            default: ;
          endcase
        end
        S_ROT: step_q <= step_q + 1'b1;
        S_MUL: mi_q <= mi_q + 1'b1;
        S_BOUND: begin
          bi_q <= bi_q + 1'b1;
          if (bx < min_x_q) min_x_q <= bx;
          if (bx > max_x_q) max_x_q <= bx;
          if (by < min_y_q) min_y_q <= by;
          if (by > max_y_q) max_y_q <= by;
          empty_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= ANG_BITS'(q_ang_i) <<< 16;
      flip_q <= q_flip_i;
      fx_q   <= q_fx_i;
      fy_q   <= q_fy_i;
      sx_q   <= q_sx_i;
      sy_q   <= q_sy_i;
    end
    if (state_q == S_ROT) begin
      if (!z_q[ANG_BITS-1]) begin
        x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_lut(sh);
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_lut(sh);
      end
    end
    if (state_q == S_MUL) prod_q[mi_q] <= neg ? -$signed(mag) : $signed(mag);
    if (state_q == S_SUM) begin
      // corners: (ax,ay), opposite, (ax,-ay), opposite
      cx_q[0] <= WB'(fx_q) + WB'(prod_q[0]) - WB'(prod_q[1]);
      cy_q[0] <= WB'(fy_q) + WB'(prod_q[2]) + WB'(prod_q[3]);
      cx_q[1] <= WB'(fx_q) - WB'(prod_q[0]) + WB'(prod_q[1]);
      cy_q[1] <= WB'(fy_q) - WB'(prod_q[2]) - WB'(prod_q[3]);
      cx_q[2] <= WB'(fx_q) + WB'(prod_q[0]) + WB'(prod_q[1]);
      cy_q[2] <= WB'(fy_q) + WB'(prod_q[2]) - WB'(prod_q[3]);
      cx_q[3] <= WB'(fx_q) - WB'(prod_q[0]) - WB'(prod_q[1]);
      cy_q[3] <= WB'(fy_q) - WB'(prod_q[2]) + WB'(prod_q[3]);
    end
  end

  assign out_valid_o = (state_q == S_OUT);
  assign min_x_o = min_x_q;
  assign max_x_o = max_x_q;
  assign min_y_o = min_y_q;
  assign max_y_o = max_y_q;
  assign empty_o = empty_q;
  assign rej_o   = rej_q;
endmodule
`default_nettype wire

### rtl/core/primitive_bounding_box.sv
// top level of the primitive bounding box accumulator
// usage:
//   s_axis carries one primitive per beat: clear, point, line or ellipse.
//   m_axis returns one beat per primitive with the box after that primitive,
//   the empty flag and a rejected flag for ellipses with a non-positive axis.
// processing:
//   a beat is registered in the queue before the back end can take it.
//   clear, point and line: the back end takes the beat, then gives the result beat.
//   ellipse: the take, then the iterative cordic (one micro-rotation per
//   cycle), a single shared multiplier (four products), a sum step, four
//   corner checks and the result beat.
//   the back end handles one primitive at a time; a two-beat queue in front
//   keeps s_axis accepting while the back end is busy.
// reset:
//   the box returns to its empty sentinels and the queue is flushed.
// stall:
//   while m_axis_tready is low the result holds and the back end waits;
//   the queue fills and then s_axis_tready drops.
`default_nettype none
module primitive_bounding_box #(
  parameter int unsigned COORD_BITS   = 32,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // first_x, first_y, second_x, second_y, rotation, zero pad
  input  wire logic [((4*COORD_BITS+16+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // low_x, high_x, low_y, high_y, box_empty, rejected, zero pad
  output logic [((4*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);
  import pbb_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned OW = ((4*CB+2+7)/8)*8;

  logic q_valid, q_ready, q_rej, q_flip;
  logic [1:0] q_cmd;
  logic signed [ROT_BITS:0] q_ang;
  logic signed [CB-1:0] q_fx, q_fy, q_sx, q_sy;
  logic signed [CB-1:0] mnx, mxx, mny, mxy;
  logic emp, rej;

  pbb_front #(.COORD_BITS(CB)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser),
    .fx_i(s_axis_tdata[CB-1:0]), .fy_i(s_axis_tdata[2*CB-1:CB]),
    .sx_i(s_axis_tdata[3*CB-1:2*CB]), .sy_i(s_axis_tdata[4*CB-1:3*CB]),
    .rot_i(s_axis_tdata[4*CB+15:4*CB]),
    .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_cmd_o(q_cmd), .q_rej_o(q_rej), .q_flip_o(q_flip), .q_ang_o(q_ang),
    .q_fx_o(q_fx), .q_fy_o(q_fy), .q_sx_o(q_sx), .q_sy_o(q_sy)
  );

  pbb_back #(.COORD_BITS(CB), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_cmd_i(q_cmd), .q_rej_i(q_rej), .q_flip_i(q_flip), .q_ang_i(q_ang),
    .q_fx_i(q_fx), .q_fy_i(q_fy), .q_sx_i(q_sx), .q_sy_i(q_sy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .min_x_o(mnx), .max_x_o(mxx), .min_y_o(mny), .max_y_o(mxy),
    .empty_o(emp), .rej_o(rej)
  );

  assign m_axis_tdata = OW'({rej, emp, mxy, mny, mxx, mnx});

  // a result beat holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // a non-empty box is ordered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !emp |-> (mnx <= mxx) && (mny <= mxy))
    else $error("box corners out of order");
  // a rejected result is never shown while the back end is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rej |-> !(q_ready))
    else $error("rejected result while back end idle");
endmodule
`default_nettype wire

### verif/tb_primitive_bounding_box.sv
// self-checking testbench of the primitive bounding box accumulator
`timescale 1ns / 1ps
module tb_primitive_bounding_box;
  import pbb_pkg::*;

  localparam int CB = 32;
  localparam int IW = ((4*CB+16+7)/8)*8;
  localparam int OW = ((4*CB+2+7)/8)*8;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint WMAX = 64'sh7fffffffffffffff;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [15:0] rot;
    logic [31:0] sy, sx, fy, fx;
  } prim_t;

  typedef struct packed {
    logic rej, emp;
    logic [31:0] hy, ly, hx, lx;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;

  primitive_bounding_box dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  longint box_lx, box_hx, box_ly, box_hy;
  bit box_emp;
  prim_t pending_prims[$];
  box_t expected_boxes[$];
  int send_idle, recv_idle;
  bit hold_send, stim_done, failed;
  longint cycles;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    if (b > 0 && a > WMAX - b) return WMAX;
    if (b < 0 && a < -WMAX - b) return -WMAX;
    return a + b;
  endfunction

  // round(a*t/2^30) half away from zero
  function automatic longint scale_q30(longint a, longint t);
    bit neg;
    logic [127:0] p;
    longint m;
    neg = (a < 0) != (t < 0);
    p = 128'(a < 0 ? -a : a) * 128'(t < 0 ? -t : t);
    p = (p + (128'd1 << 29)) >> 30;
    m = (p > 128'(WMAX)) ? WMAX : longint'(p);
    return neg ? -m : m;
  endfunction

  function automatic longint sat_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  task automatic clear_box();
    box_lx = CMAX; box_ly = CMAX; box_hx = CMIN; box_hy = CMIN; box_emp = 1;
  endtask

  task automatic grow_box(longint x, longint y);
    if (x < box_lx) box_lx = x;
    if (x > box_hx) box_hx = x;
    if (y < box_ly) box_ly = y;
    if (y > box_hy) box_hy = y;
    box_emp = 0;
  endtask

  task automatic grow_pair(longint cx, longint cy, longint dx, longint dy);
    grow_box(sat_coord(sum_sat(cx, dx)), sat_coord(sum_sat(cy, dy)));
    grow_box(sat_coord(sum_sat(cx, -dx)), sat_coord(sum_sat(cy, -dy)));
  endtask

  // fixed-length cordic, angle folded into (-90, 90]
  task automatic rot_sin_cos(logic [15:0] rot, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = longint'($signed(rot)) % longint'(FULL_TURN);
    flip = 0;
    if (a < 0) a += FULL_TURN;
    if (a > QUARTER_TURN && a <= 3*QUARTER_TURN) begin
      a -= HALF_TURN; flip = 1;
    end else if (a > 3*QUARTER_TURN) begin
      a -= FULL_TURN;
    end
    x = 652032874; y = 0; z = a * 65536;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i); dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
      end
    end
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    if (x < -64'sd1073741824) x = -64'sd1073741824;
    if (y > 64'sd1073741824) y = 64'sd1073741824;
    if (y < -64'sd1073741824) y = -64'sd1073741824;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_box(prim_t p);
    longint fx, fy, sx, sy, s, c, cax, say, sax, cay;
    box_t r;
    fx = $signed(p.fx); fy = $signed(p.fy);
    sx = $signed(p.sx); sy = $signed(p.sy);
    r.rej = 0;
    case (cmd_e'(p.cmd))
      CMD_CLEAR: clear_box();
      CMD_POINT: grow_box(fx, fy);
      CMD_LINE: begin
        grow_box(fx, fy); grow_box(sx, sy);
      end
      default: begin
        if (sx <= 0 || sy <= 0) begin
          r.rej = 1;
        end else begin
          rot_sin_cos(p.rot, s, c);
          cax = scale_q30(sx, c); say = scale_q30(sy, s);
          sax = scale_q30(sx, s); cay = scale_q30(sy, c);
          grow_pair(fx, fy, sum_sat(cax, -say), sum_sat(sax, cay));
          grow_pair(fx, fy, sum_sat(cax, say), sum_sat(sax, -cay));
        end
      end
    endcase
    r.lx = box_lx[31:0]; r.hx = box_hx[31:0];
    r.ly = box_ly[31:0]; r.hy = box_hy[31:0];
    r.emp = box_emp;
    expected_boxes.push_back(r);
  endtask

  // driver: beat leaves the queue when accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_box(pending_prims.pop_front());
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_prims.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= IW'({pending_prims[0].rot, pending_prims[0].sy, pending_prims[0].sx,
                               pending_prims[0].fy, pending_prims[0].fx});
          s_axis_tuser <= pending_prims[0].cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    box_t got, exp_box;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = box_t'(m_axis_tdata[4*CB+1:0]);
        if (expected_boxes.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failed = 1;
        end else begin
          exp_box = expected_boxes.pop_front();
          if (got !== exp_box) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_box, got);
            failed = 1;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(255) << 16;
      3: return 32'($signed($urandom_range(2000)) - 1000) << 12;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_prim(cmd_e c, logic [31:0] a, b, d, e, logic [15:0] r);
    prim_t p;
    p.cmd = c; p.fx = a; p.fy = b; p.sx = d; p.sy = e; p.rot = r;
    pending_prims.push_back(p);
  endtask

  task automatic add_random(int n);
    prim_t p;
    repeat (n) begin
      p.cmd = (($urandom_range(29) == 0) ? CMD_CLEAR : cmd_e'(2'($urandom_range(1, 3))));
      p.fx = rand_coord(); p.fy = rand_coord();
      p.sx = rand_coord(); p.sy = rand_coord();
      // mostly valid axes so ellipses reach the cordic
      if (p.cmd == CMD_ELLIPSE && $urandom_range(9) != 0) begin
        if ($signed(p.sx) <= 0) p.sx = ~p.sx;
        if ($signed(p.sx) <= 0) p.sx = 32'd1;
        if ($signed(p.sy) <= 0) p.sy = ~p.sy;
        if ($signed(p.sy) <= 0) p.sy = 32'd1;
      end
      p.rot = 16'($urandom);
      pending_prims.push_back(p);
    end
  endtask

  task automatic drain();
    while (pending_prims.size() > 0 || expected_boxes.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    clear_box();
    cycles = 0; failed = 0; hold_send = 0;
    send_idle = 28; recv_idle = 68;
    // directed: extremes, every command, rejection and saturation
    add_prim(CMD_POINT, 32'h7fffffff, 32'h80000000, 0, 0, 16'd0);
    add_prim(CMD_POINT, 32'h80000000, 32'h7fffffff, 0, 0, 16'd0);
    add_prim(CMD_CLEAR, 0, 0, 0, 0, 16'd0);
    add_prim(CMD_ELLIPSE, 0, 0, 0, 32'h10000, 16'd0);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h10000, 32'hffff0000, 16'd0);
    add_prim(CMD_LINE, 32'hfff00000, 32'h00100000, 32'h00200000, 32'hffe00000, 16'd0);
    add_prim(CMD_ELLIPSE, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00010000, 16'd0);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00030000, 32'h00010000, 16'd5760);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00030000, 32'h00010000, 16'd11520);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00030000, 32'h00010000, 16'd17280);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00050000, 32'h00020000, 16'h7fff);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00050000, 32'h00020000, 16'h8000);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00050000, 32'h00020000, 16'hffff);
    add_prim(CMD_ELLIPSE, 32'h7fff0000, 32'h80010000, 32'h7fffffff, 32'h7fffffff, 16'd2880);
    add_prim(CMD_ELLIPSE, 0, 0, 32'h00000001, 32'h00000001, 16'd1);
    add_prim(CMD_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
    add_prim(CMD_LINE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_random(520);
    drain();
    // after every result is back, the sender idles more than the receiver
    send_idle = 68; recv_idle = 28;
    add_random(540);
    drain();
    send_idle = 0; recv_idle = 0;
    add_random(540);
    drain();
    repeat (40) @(posedge clk_i);
    if (!failed && expected_boxes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
